### src/vwpi_pkg.sv
// Shared types, codes and constants of the velocity watchdog pose integrator.
package vwpi_pkg;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    REQ_CMD    = 2'd0,
    REQ_STATUS = 2'd1,
    REQ_TICK   = 2'd2
  } req_t;

  // Result status carried on the output tuser
  typedef enum logic [1:0] {
    ST_STANDBY  = 2'd0,
    ST_TRACKING = 2'd1,
    ST_HOLDING  = 2'd2
  } status_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_INTEGRATE = 2'd1,
    CFG_RESPECT   = 2'd2
  } cfg_idx_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_TWAIT = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_QGO   = 7'b0010000,
    S_QWAIT = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  // Accumulator shift selects of the multiply-accumulate unit
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_32 = 2'd1;
  localparam logic [1:0] SH_64 = 2'd2;

  typedef struct packed {
    logic       vld;
    logic       clr;
    logic       neg;
    logic [1:0] sh;
  } mac_op_t;

  // Capture actions of the multiply microprogram
  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_TX,
    CAP_TY,
    CAP_AX,
    CAP_AY,
    CAP_M,
    CAP_YD,
    CAP_YAW
  } cap_t;

  localparam int MUL_W   = 33;
  localparam int ACC_W   = 96;
  localparam int MAG_W   = 41;
  localparam int CORD_W  = 34;
  localparam int TRIG_W  = 24;
  localparam int CORDIC_STEPS = 24;
  localparam logic [CORD_W-1:0] CORDIC_GAIN = 34'd652032874;
  localparam logic [31:0] YAW_SCALE = 32'd2935890503;
  localparam logic [4:0]  QUAT_FRAC = 5'd15;

  function automatic logic [CORD_W-1:0] atan_bam(input logic [4:0] idx);
    logic [CORD_W-1:0] v;
    case (idx)
      5'd0:  v = 34'd536870912;
      5'd1:  v = 34'd316933406;
      5'd2:  v = 34'd167458907;
      5'd3:  v = 34'd85004756;
      5'd4:  v = 34'd42667331;
      5'd5:  v = 34'd21354465;
      5'd6:  v = 34'd10679838;
      5'd7:  v = 34'd5340245;
      5'd8:  v = 34'd2670163;
      5'd9:  v = 34'd1335087;
      5'd10: v = 34'd667544;
      5'd11: v = 34'd333772;
      5'd12: v = 34'd166886;
      5'd13: v = 34'd83443;
      5'd14: v = 34'd41722;
      5'd15: v = 34'd20861;
      5'd16: v = 34'd10430;
      5'd17: v = 34'd5215;
      5'd18: v = 34'd2608;
      5'd19: v = 34'd1304;
      5'd20: v = 34'd652;
      5'd21: v = 34'd326;
      5'd22: v = 34'd163;
      5'd23: v = 34'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### src/vwpi_mac.sv
// Shared signed multiply-accumulate unit with a registered product stage.
module vwpi_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vwpi_pkg::mac_op_t                   op,
  input  logic signed [vwpi_pkg::MUL_W-1:0]   a,
  input  logic signed [vwpi_pkg::MUL_W-1:0]   b,
  output logic signed [vwpi_pkg::ACC_W-1:0]   acc
);
  import vwpi_pkg::*;

  logic signed [2*MUL_W-1:0] prod_r;
  mac_op_t                   ctl_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   term_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= op;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  always_comb begin
    term = ACC_W'(ctl_r.neg ? -prod_r : prod_r);
    case (ctl_r.sh)
      SH_32:   term_sh = term <<< 32;
      SH_64:   term_sh = term <<< 64;
      default: term_sh = term;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl_r.vld) begin
      acc_r <= (ctl_r.clr ? '0 : acc_r) + term_sh;
    end
  end

  assign acc = acc_r;

endmodule

### src/vwpi_cordic.sv
// Iterative rotation CORDIC giving rounded, saturated sine and cosine of a binary angle.
module vwpi_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [31:0]                       angle,
  input  logic [4:0]                        frac,
  output logic                              done,
  output logic signed [vwpi_pkg::TRIG_W-1:0] sin_o,
  output logic signed [vwpi_pkg::TRIG_W-1:0] cos_o
);
  import vwpi_pkg::*;

  logic signed [CORD_W-1:0] x_r, y_r, z_r;
  logic signed [CORD_W-1:0] xs, ys, at;
  logic [4:0]               i_r;
  logic                     run_r, rnd_r, neg_r, done_r;
  logic [4:0]               frac_r;
  logic [31:0]              ang_f;
  logic                     fold;
  logic signed [TRIG_W-1:0] sin_r, cos_r;

  function automatic logic signed [TRIG_W-1:0] round_sat(input logic signed [CORD_W-1:0] v,
                                                       input logic [4:0] fr,
                                                       input logic ng);
    logic [4:0]               sh;
    logic signed [CORD_W+1:0] half, r, lim;
    sh   = 5'd30 - fr;
    half = (CORD_W+2)'(1) <<< (sh - 5'd1);
    r    = ((CORD_W+2)'(v) + half) >>> sh;
    lim  = (CORD_W+2)'(1) <<< fr;
    if (ng) r = -r;
    if (r > lim - 1) r = lim - 1;
    if (r < -lim) r = -lim;
    return r[TRIG_W-1:0];
  endfunction

  // fold the second and third quadrant by a half turn, negate at the end
  assign fold  = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
  assign ang_f = fold ? angle + 32'h8000_0000 : angle;
  assign xs    = x_r >>> i_r;
  assign ys    = y_r >>> i_r;
  assign at    = atan_bam(i_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        i_r   <= '0;
      end else if (run_r) begin
        i_r <= i_r + 5'd1;
        if (i_r == 5'(CORDIC_STEPS - 1)) begin
          run_r <= 1'b0;
          rnd_r <= 1'b1;
        end
      end else if (rnd_r) begin
        rnd_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= CORD_W'($signed(ang_f));
      neg_r  <= fold;
      frac_r <= frac;
    end else if (run_r) begin
      if (!z_r[CORD_W-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end else if (rnd_r) begin
      sin_r <= round_sat(y_r, frac_r, neg_r);
      cos_r <= round_sat(x_r, frac_r, neg_r);
    end
  end

  assign done  = done_r;
  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

### src/velocity_watchdog_pose_integrator_top.sv
// Top level: velocity command watchdog with planar dead-reckoning pose integration.
// Commands and status updates are taken while idle. A tick blocked by status gives a
// standby result straight from the finish state. Any other tick runs the shared CORDIC for
// the half-yaw quaternion, and when it integrates it first runs the CORDIC for the heading
// and then a 23-entry microprogram of an issue and an accumulate step per entry on the
// one shared multiply-accumulate unit. The input is not ready while a tick is at work; a
// finished result waits in the output register while the next item is taken.
module velocity_watchdog_pose_integrator_top #(
  parameter int TIME_WIDTH = 48,
  parameter int TRIG_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // timestamp_us[47:0], vel_x[63:48], vel_y[79:64], yaw_rate[95:80],
  // estop_flag[96], fault_flag[97], mode_active[98], zero[103:99]
  input  logic [103:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_time_us[47:0], pos_x_nm[95:48], pos_y_nm[143:96], heading[175:144],
  // quat_z[191:176], quat_w[207:192], used_vel_x[223:208], used_vel_y[239:224],
  // used_yaw_rate[255:240]
  output logic [255:0] out_tdata,
  // status[1:0]
  output logic [1:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data
);
  import vwpi_pkg::*;

  localparam int          F         = TRIG_BITS - 1;
  localparam logic [4:0]  TRIG_FRAC = 5'(F);
  localparam logic [47:0] TIME_MASK = 48'((65'd1 << TIME_WIDTH) - 65'd1);
  localparam logic [64:0] HALF      = 65'd1 << (F - 1);
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic [5:0]  LAST_STEP = 6'd45;

  state_t state_r, state_nxt;

  logic [23:0] timeout_r;
  logic        integ_r, respect_r;
  logic        have_cmd_r, tick_seen_r, have_status_r, allows_r;
  logic signed [15:0] svx_r, svy_r, svr_r;
  logic [47:0] cmd_time_r, prev_tick_r, now_r, dt_r;
  logic signed [63:0] acc_x_r, acc_y_r;
  logic [31:0] acc_yaw_r;
  logic        blocked_r, timed_out_r;
  logic signed [15:0] vx_r, vy_r, vr_r;
  logic signed [TRIG_BITS-1:0] s_r, c_r;
  logic [MAG_W-1:0] mag_a_r, mag_b_r;
  logic        neg_a_r, neg_b_r;
  logic [63:0] m_r;
  logic [31:0] yawd_r;
  logic signed [15:0] qz_r, qw_r;
  logic [5:0]  step_r;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [255:0] out_data_r;

  logic        in_acc, cfg_acc, out_load;
  logic [47:0] in_now;
  logic [47:0] dt_nxt, age;
  logic        timed_out_nxt, integ_go, blocked_nxt;
  logic [4:0]  entry;
  mac_op_t     mac_op;
  logic signed [MUL_W-1:0] mac_a, mac_b;
  logic signed [ACC_W-1:0] mac_acc;
  cap_t        cap;
  logic        cor_start, cor_done;
  logic [31:0] cor_angle;
  logic [4:0]  cor_frac;
  logic signed [TRIG_W-1:0] cor_sin, cor_cos;
  logic [15:0] vr_abs;
  logic [31:0] yaw_d;
  logic [ACC_W-1:0] acc_abs;
  logic [63:0] yaw_rnd;
  logic [47:0] px48, py48;

  function automatic logic signed [63:0] advance(input logic signed [63:0] acc,
                                                 input logic [ACC_W-1:0] p,
                                                 input logic ng);
    logic [64:0]        ph;
    logic [63:0]        q;
    logic signed [64:0] sum;
    logic signed [63:0] r;
    ph = {1'b0, p[63:0]} + HALF;
    q  = 64'(ph >> F);
    if (p == '0) begin
      r = acc;
    end else if ((p[ACC_W-1:64] != '0) || ph[64]) begin
      r = ng ? S64_MIN : S64_MAX;
    end else begin
      sum = ng ? {acc[63], acc} - {1'b0, q} : {acc[63], acc} + {1'b0, q};
      if (sum[64] != sum[63]) r = sum[64] ? S64_MIN : S64_MAX;
      else r = sum[63:0];
    end
    return r;
  endfunction

  function automatic logic [47:0] clamp48(input logic signed [63:0] v);
    logic [47:0] r;
    if (v > 64'sh0000_7FFF_FFFF_FFFF) r = 48'h7FFF_FFFF_FFFF;
    else if (v < -64'sh0000_8000_0000_0000) r = 48'h8000_0000_0000;
    else r = v[47:0];
    return r;
  endfunction

  vwpi_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (mac_op),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (mac_acc)
  );

  vwpi_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_angle),
    .frac  (cor_frac),
    .done  (cor_done),
    .sin_o (cor_sin),
    .cos_o (cor_cos)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_tready);
  assign in_now    = in_tdata[47:0] & TIME_MASK;
  assign blocked_nxt = respect_r && !(have_status_r && allows_r);

  // tick timing and watchdog
  assign age    = now_r - cmd_time_r;
  assign dt_nxt = (tick_seen_r && (now_r >= prev_tick_r)) ? now_r - prev_tick_r : '0;
  assign timed_out_nxt = !have_cmd_r ||
      ((timeout_r != '0) && (now_r > cmd_time_r) && (age > 48'(timeout_r)));
  assign integ_go = integ_r && (dt_nxt != '0);

  assign cor_start = ((state_r == S_PREP) && integ_go) || (state_r == S_QGO);
  assign cor_angle = (state_r == S_QGO) ? {acc_yaw_r[31], acc_yaw_r[31:1]} : acc_yaw_r;
  assign cor_frac  = (state_r == S_QGO) ? QUAT_FRAC : TRIG_FRAC;

  assign vr_abs  = vr_r[15] ? 16'(-vr_r) : vr_r;
  assign acc_abs = mac_acc[ACC_W-1] ? ACC_W'(-mac_acc) : ACC_W'(mac_acc);
  assign yaw_rnd = mac_acc[63:0] + 64'h8000_0000;
  assign yaw_d   = mac_acc[31:0] + yawd_r;

  // multiply microprogram: even step issues, odd step accumulates
  assign entry = step_r[5:1];
  always_comb begin
    mac_op = '0;
    mac_a  = '0;
    mac_b  = '0;
    cap    = CAP_NONE;
    case (entry)
      5'd0:  begin mac_op = '{1'b1, 1'b1, 1'b0, SH_0}; mac_a = MUL_W'(vx_r); mac_b = MUL_W'(c_r); end
      5'd1:  begin mac_op = '{1'b1, 1'b0, 1'b1, SH_0}; mac_a = MUL_W'(vy_r); mac_b = MUL_W'(s_r); end
      5'd2:  cap = CAP_TX;
      5'd3:  begin mac_op = '{1'b1, 1'b1, 1'b0, SH_0}; mac_a = MUL_W'(vx_r); mac_b = MUL_W'(s_r); end
      5'd4:  begin mac_op = '{1'b1, 1'b0, 1'b0, SH_0}; mac_a = MUL_W'(vy_r); mac_b = MUL_W'(c_r); end
      5'd5:  cap = CAP_TY;
      5'd6:  begin mac_op = '{1'b1, 1'b1, 1'b0, SH_0};
        mac_a = {1'b0, mag_a_r[31:0]}; mac_b = {1'b0, dt_r[31:0]}; end
      5'd7:  begin mac_op = '{1'b1, 1'b0, 1'b0, SH_32};
        mac_a = {1'b0, mag_a_r[31:0]}; mac_b = MUL_W'(dt_r[47:32]); end
      5'd8:  begin mac_op = '{1'b1, 1'b0, 1'b0, SH_32};
        mac_a = MUL_W'(mag_a_r[MAG_W-1:32]); mac_b = {1'b0, dt_r[31:0]}; end
      5'd9:  begin mac_op = '{1'b1, 1'b0, 1'b0, SH_64};
        mac_a = MUL_W'(mag_a_r[MAG_W-1:32]); mac_b = MUL_W'(dt_r[47:32]); end
      5'd10: cap = CAP_AX;
      5'd11: begin mac_op = '{1'b1, 1'b1, 1'b0, SH_0};
        mac_a = {1'b0, mag_b_r[31:0]}; mac_b = {1'b0, dt_r[31:0]}; end
      5'd12: begin mac_op = '{1'b1, 1'b0, 1'b0, SH_32};
        mac_a = {1'b0, mag_b_r[31:0]}; mac_b = MUL_W'(dt_r[47:32]); end
      5'd13: begin mac_op = '{1'b1, 1'b0, 1'b0, SH_32};
        mac_a = MUL_W'(mag_b_r[MAG_W-1:32]); mac_b = {1'b0, dt_r[31:0]}; end
      5'd14: begin mac_op = '{1'b1, 1'b0, 1'b0, SH_64};
        mac_a = MUL_W'(mag_b_r[MAG_W-1:32]); mac_b = MUL_W'(dt_r[47:32]); end
      5'd15: cap = CAP_AY;
      5'd16: begin mac_op = '{1'b1, 1'b1, 1'b0, SH_0};
        mac_a = MUL_W'(vr_abs); mac_b = {1'b0, dt_r[31:0]}; end
      5'd17: begin mac_op = '{1'b1, 1'b0, 1'b0, SH_32};
        mac_a = MUL_W'(vr_abs); mac_b = MUL_W'(dt_r[47:32]); end
      5'd18: cap = CAP_M;
      5'd19: begin mac_op = '{1'b1, 1'b1, 1'b0, SH_0};
        mac_a = {1'b0, m_r[31:0]}; mac_b = {1'b0, YAW_SCALE}; end
      5'd20: cap = CAP_YD;
      5'd21: begin mac_op = '{1'b1, 1'b1, 1'b0, SH_0};
        mac_a = {1'b0, m_r[63:32]}; mac_b = {1'b0, YAW_SCALE}; end
      5'd22: cap = CAP_YAW;
      default: cap = CAP_NONE;
    endcase
    if ((state_r != S_MUL) || step_r[0]) begin
      mac_op = '0;
      cap    = CAP_NONE;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == REQ_TICK)) state_nxt = blocked_nxt ? S_FIN : S_PREP;
      end
      S_PREP:  state_nxt = integ_go ? S_TWAIT : S_QGO;
      S_TWAIT: if (cor_done) state_nxt = S_MUL;
      S_MUL:   if (step_r == LAST_STEP) state_nxt = S_QGO;
      S_QGO:   state_nxt = S_QWAIT;
      S_QWAIT: if (cor_done) state_nxt = S_FIN;
      S_FIN:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      timeout_r     <= 24'd250000;
      integ_r       <= 1'b1;
      respect_r     <= 1'b1;
      have_cmd_r    <= 1'b0;
      tick_seen_r   <= 1'b0;
      have_status_r <= 1'b0;
      allows_r      <= 1'b0;
      svx_r         <= '0;
      svy_r         <= '0;
      svr_r         <= '0;
      cmd_time_r    <= '0;
      prev_tick_r   <= '0;
      acc_x_r       <= '0;
      acc_y_r       <= '0;
      acc_yaw_r     <= '0;
      step_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        case (cfg_index)
          CFG_TIMEOUT:   timeout_r <= cfg_data;
          CFG_INTEGRATE: integ_r   <= cfg_data[0];
          CFG_RESPECT:   respect_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        case (in_tuser)
          REQ_CMD: begin
            svx_r      <= in_tdata[63:48];
            svy_r      <= in_tdata[79:64];
            svr_r      <= in_tdata[95:80];
            cmd_time_r <= in_now;
            have_cmd_r <= 1'b1;
          end
          REQ_STATUS: begin
            allows_r      <= !in_tdata[96] && !in_tdata[97] && in_tdata[98];
            have_status_r <= 1'b1;
          end
          default: ;
        endcase
      end
      if (state_r == S_PREP) begin
        prev_tick_r <= now_r;
        tick_seen_r <= 1'b1;
      end
      if (state_r == S_MUL) step_r <= step_r + 6'd1;
      else step_r <= '0;
      case (cap)
        CAP_AX:  acc_x_r <= advance(acc_x_r, mac_acc, neg_a_r);
        CAP_AY:  acc_y_r <= advance(acc_y_r, mac_acc, neg_b_r);
        CAP_YAW: acc_yaw_r <= acc_yaw_r + (vr_r[15] ? -yaw_d : yaw_d);
        default: ;
      endcase
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == REQ_TICK)) begin
      now_r     <= in_now;
      blocked_r <= blocked_nxt;
    end
    if (state_r == S_PREP) begin
      dt_r        <= dt_nxt;
      timed_out_r <= timed_out_nxt;
      vx_r        <= timed_out_nxt ? 16'sd0 : svx_r;
      vy_r        <= timed_out_nxt ? 16'sd0 : svy_r;
      vr_r        <= timed_out_nxt ? 16'sd0 : svr_r;
    end
    if ((state_r == S_TWAIT) && cor_done) begin
      s_r <= cor_sin[TRIG_BITS-1:0];
      c_r <= cor_cos[TRIG_BITS-1:0];
    end
    if ((state_r == S_QWAIT) && cor_done) begin
      qz_r <= cor_sin[15:0];
      qw_r <= cor_cos[15:0];
    end
    case (cap)
      CAP_TX: begin mag_a_r <= acc_abs[MAG_W-1:0]; neg_a_r <= mac_acc[ACC_W-1]; end
      CAP_TY: begin mag_b_r <= acc_abs[MAG_W-1:0]; neg_b_r <= mac_acc[ACC_W-1]; end
      CAP_M:  m_r    <= mac_acc[63:0];
      CAP_YD: yawd_r <= yaw_rnd[63:32];
      default: ;
    endcase
    if (out_load) begin
      if (blocked_r) begin
        out_status_r <= ST_STANDBY;
        out_data_r   <= {208'd0, now_r};
      end else begin
        out_status_r <= timed_out_r ? ST_HOLDING : ST_TRACKING;
        out_data_r   <= {vr_r, vy_r, vx_r, qw_r, qz_r, acc_yaw_r, py48, px48, now_r};
      end
    end
  end

  assign px48 = clamp48(acc_x_r);
  assign py48 = clamp48(acc_y_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // a tick that is taken always leaves idle
  a_tick_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == REQ_TICK)) |=> (state_r != S_IDLE))
    else $error("tick accepted but sequencer stayed idle");

  // the shared CORDIC finishes only while the sequencer waits for it
  a_cordic_expected: assert property (@(posedge clk) disable iff (!rst_n)
    cor_done |-> ((state_r == S_TWAIT) || (state_r == S_QWAIT)))
    else $error("CORDIC result arrived outside a wait state");

  // a new result comes only from the finish state
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finish state");

endmodule
